### src/polynomial_evaluator_top_macros.svh
// assertion macros for the polynomial evaluator
`ifndef POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH

// same-cycle implication
`define PE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/polyeval_pkg.sv
package polyeval_pkg;

   localparam int DEFAULT_MAX_DEGREE = 15;

   localparam int DEG_W   = 4;
   localparam int COEF_W  = 16;
   localparam int X_W     = 16;
   localparam int ACC_W   = 32;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   typedef struct packed {
      logic capture;
      logic load;
      logic mul;
      logic step;
      logic wr;
   } dp_cmd_type;

endpackage

### src/polyeval_dp.sv
module polyeval_dp #(
   parameter int MAX_DEGREE = polyeval_pkg::DEFAULT_MAX_DEGREE,
   parameter int IDX_W      = $clog2(MAX_DEGREE + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  polyeval_pkg::dp_cmd_type                cmd,
   input  logic [IDX_W-1:0]                        rd_addr,
   input  logic [IDX_W-1:0]                        wr_addr,
   input  logic signed [polyeval_pkg::COEF_W-1:0]  coef_value,
   input  logic signed [polyeval_pkg::X_W-1:0]     x_value,
   output logic signed [polyeval_pkg::ACC_W-1:0]   poly_value,
   output logic                                    saturated
);

   localparam int DEPTH  = MAX_DEGREE + 1;
   localparam int ACC_W  = polyeval_pkg::ACC_W;
   localparam int COEF_W = polyeval_pkg::COEF_W;
   localparam int X_W    = polyeval_pkg::X_W;
   localparam int PROD_W = ACC_W + X_W;
   localparam int FRAC   = 12;
   localparam int RND_W  = PROD_W - FRAC;
   localparam int CSH    = 4;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic signed [COEF_W-1:0] coef_mem_ff [DEPTH];
   logic [DEPTH-1:0]         valid_ff;
   logic signed [COEF_W-1:0] rd_data_ff;
   logic                     rd_valid_ff;
   logic signed [X_W-1:0]    x_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     flag_ff;
   logic                     flag_in;

   logic signed [COEF_W-1:0] coef;
   logic signed [ACC_W-1:0]  coef_q16;
   logic signed [RND_W-1:0]  rnd;
   logic                     sat_mul;
   logic signed [ACC_W-1:0]  acc_mul;
   logic signed [ACC_W:0]    sum;
   logic                     sat_add;
   logic signed [ACC_W-1:0]  acc_add;

   // coefficient store, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         coef_mem_ff[wr_addr] <= coef_value;
      end
      rd_data_ff <= coef_mem_ff[rd_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      coef     = rd_valid_ff ? rd_data_ff : '0;
      coef_q16 = {{(ACC_W-COEF_W-CSH){coef[COEF_W-1]}}, coef, {CSH{1'b0}}};

      prod_in  = acc_ff * x_ff;

      // round half up: floor(p / 4096) plus bit 11
      rnd      = prod_ff[PROD_W-1:FRAC] + RND_W'(prod_ff[FRAC-1]);
      sat_mul  = (rnd[RND_W-1:ACC_W-1] != '0) && (rnd[RND_W-1:ACC_W-1] != '1);
      acc_mul  = sat_mul ? (rnd[RND_W-1] ? ACC_MIN : ACC_MAX) : rnd[ACC_W-1:0];

      sum      = {acc_mul[ACC_W-1], acc_mul} + {coef_q16[ACC_W-1], coef_q16};
      sat_add  = sum[ACC_W] != sum[ACC_W-1];
      acc_add  = sat_add ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

      acc_in   = acc_ff;
      flag_in  = flag_ff;
      if (cmd.capture) begin
         flag_in = 1'b0;
      end
      if (cmd.load) begin
         acc_in = coef_q16;
      end
      if (cmd.step) begin
         acc_in  = acc_add;
         flag_in = flag_ff | sat_mul | sat_add;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= x_value;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff  <= acc_in;
      flag_ff <= flag_in;
   end

   assign poly_value = acc_ff;
   assign saturated  = flag_ff;

endmodule

### src/polyeval_ctrl.sv
module polyeval_ctrl #(
   parameter int MAX_DEGREE = polyeval_pkg::DEFAULT_MAX_DEGREE,
   parameter int IDX_W      = $clog2(MAX_DEGREE + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_type,
   input  logic [polyeval_pkg::DEG_W-1:0]    coef_index,
   output logic                              busy,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [polyeval_pkg::DEG_W-1:0]    csr_degree,
   output logic                              rsp_strobe,
   output polyeval_pkg::dp_cmd_type          cmd,
   output logic [IDX_W-1:0]                  rd_addr,
   output logic [IDX_W-1:0]                  wr_addr
);

   localparam int DEG_W = polyeval_pkg::DEG_W;
   localparam int CMP_W = (IDX_W > DEG_W) ? IDX_W : DEG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_INIT,
      ST_MUL,
      ST_ACC
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   logic [DEG_W-1:0] degree_ff;

   logic             accept;
   logic [CMP_W-1:0] deg_ext;
   logic [CMP_W-1:0] widx_ext;
   logic [IDX_W-1:0] deg_clamped;

   always_comb begin
      accept      = start && (state_ff == ST_IDLE);
      deg_ext     = CMP_W'(degree_ff);
      widx_ext    = CMP_W'(coef_index);
      deg_clamped = (deg_ext > CMP_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
                                                    : deg_ext[IDX_W-1:0];

      cmd.capture = accept && (req_type == polyeval_pkg::REQ_EVAL);
      cmd.wr      = accept && (req_type == polyeval_pkg::REQ_WRITE)
                    && (widx_ext <= CMP_W'(MAX_DEGREE));
      cmd.load    = state_ff == ST_INIT;
      cmd.mul     = state_ff == ST_MUL;
      cmd.step    = state_ff == ST_ACC;

      wr_addr     = widx_ext[IDX_W-1:0];
      rd_addr     = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         degree_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            degree_ff <= csr_degree;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  idx_ff   <= deg_clamped;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_INIT;
            end
            ST_INIT, ST_ACC: begin
               if (idx_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff - IDX_W'(1);
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff != ST_IDLE;
   assign csr_ready  = state_ff == ST_IDLE;
   assign rsp_strobe = rsp_valid_ff;

endmodule

### src/polynomial_evaluator_top.sv
// Polynomial evaluator by Horner's rule, Q4.12 coefficients and point, Q16.16 result.
// A request is taken when start is high and busy is low. A write request (req_type 0)
// stores one coefficient in that same cycle, gives no result and leaves busy low. An
// evaluate request (req_type 1) keeps busy high while it fetches the top coefficient,
// loads it, then takes each remaining coefficient through the 32x16 multiplier and
// then through rounding, adding and saturating; the top coefficient index is the
// csr_degree value clamped to MAX_DEGREE. The result appears on rsp_poly_value and
// rsp_saturated for exactly one cycle with rsp_strobe high, the first cycle with busy
// low; there is no back-pressure, so the receiver must take it then. A new request
// may be given in the strobe cycle. The coefficient table reads as zero after reset.
// csr_degree is written only while busy is low.
`include "polynomial_evaluator_top_macros.svh"

module polynomial_evaluator_top #(
   parameter int MAX_DEGREE = polyeval_pkg::DEFAULT_MAX_DEGREE
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_type,
   input  logic [polyeval_pkg::DEG_W-1:0]          req_coef_index,
   input  logic signed [polyeval_pkg::COEF_W-1:0]  req_coef_value,
   input  logic signed [polyeval_pkg::X_W-1:0]     req_x_value,
   output logic                                    rsp_strobe,
   output logic signed [polyeval_pkg::ACC_W-1:0]   rsp_poly_value,
   output logic                                    rsp_saturated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [polyeval_pkg::DEG_W-1:0]          csr_degree
);

   localparam int IDX_W = $clog2(MAX_DEGREE + 1);

   polyeval_pkg::dp_cmd_type cmd;
   logic [IDX_W-1:0]         rd_addr;
   logic [IDX_W-1:0]         wr_addr;

   polyeval_ctrl #(
      .MAX_DEGREE (MAX_DEGREE),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .coef_index (req_coef_index),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_degree (csr_degree),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   polyeval_dp #(
      .MAX_DEGREE (MAX_DEGREE),
      .IDX_W      (IDX_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .coef_value (req_coef_value),
      .x_value    (req_x_value),
      .poly_value (rsp_poly_value),
      .saturated  (rsp_saturated)
   );

   `PE_ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_strobe, !busy, "result beat while busy")
   `PE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result beat repeated")
   `PE_ASSERT_NEXT(a_eval_goes_busy, clock, reset, start && !busy && req_type, busy, "evaluate not started")
   `PE_ASSERT_NEXT(a_write_no_result, clock, reset, start && !busy && !req_type, !busy && !rsp_strobe, "write made work")

endmodule

### dv/polynomial_evaluator_checker.sv
`timescale 1ns / 1ps

module polynomial_evaluator_checker #(
   parameter int MAX_DEGREE = polyeval_pkg::DEFAULT_MAX_DEGREE
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic                                    req_type,
   input  logic [polyeval_pkg::DEG_W-1:0]          req_coef_index,
   input  logic signed [polyeval_pkg::COEF_W-1:0]  req_coef_value,
   input  logic signed [polyeval_pkg::X_W-1:0]     req_x_value,
   input  logic                                    rsp_strobe,
   input  logic signed [polyeval_pkg::ACC_W-1:0]   rsp_poly_value,
   input  logic                                    rsp_saturated,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [polyeval_pkg::DEG_W-1:0]          csr_degree,
   output int                                      error_count,
   output int                                      pending_count
);

   localparam int DEG_W  = polyeval_pkg::DEG_W;
   localparam int COEF_W = polyeval_pkg::COEF_W;
   localparam int X_W    = polyeval_pkg::X_W;
   localparam int ACC_W  = polyeval_pkg::ACC_W;

   typedef struct packed {
      logic signed [ACC_W-1:0] poly_value;
      logic                    saturated;
   } poly_result_type;

   logic signed [COEF_W-1:0] coef_shadow [0:MAX_DEGREE];
   logic [DEG_W-1:0]         degree_shadow;
   poly_result_type          expected_results [$];
   int                       mismatches = 0;

   function automatic longint clip_acc(input longint v, inout bit sat);
      longint lo;
      longint hi;
      lo = -(longint'(1) <<< (ACC_W - 1));
      hi = (longint'(1) <<< (ACC_W - 1)) - 1;
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // horner over the shadow table, Q16.16 accumulator saturated at every step
   function automatic poly_result_type horner_eval(input logic signed [X_W-1:0] x);
      longint          acc;
      int              top;
      bit              sat;
      poly_result_type r;
      top = (int'(degree_shadow) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_shadow);
      sat = 1'b0;
      acc = longint'(coef_shadow[top]) * 16;
      for (int i = top; i > 0; i--) begin
         acc = clip_acc((acc * longint'(x) + 2048) >>> 12, sat);
         acc = clip_acc(acc + longint'(coef_shadow[i-1]) * 16, sat);
      end
      r.poly_value = acc[ACC_W-1:0];
      r.saturated  = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      poly_result_type want;
      if (reset) begin
         foreach (coef_shadow[i]) coef_shadow[i] = '0;
         degree_shadow = '0;
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no evaluation outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_poly_value !== want.poly_value) begin
                  $error("poly_value: expected %0d, got %0d", want.poly_value, rsp_poly_value);
                  mismatches++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, rsp_saturated);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (req_type == polyeval_pkg::REQ_WRITE) begin
               if (int'(req_coef_index) <= MAX_DEGREE)
                  coef_shadow[req_coef_index] = req_coef_value;
            end else begin
               expected_results.push_back(horner_eval(req_x_value));
            end
         end
         if (csr_valid && csr_ready)
            degree_shadow = csr_degree;
      end
      error_count   <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

### dv/tb_polynomial_evaluator_top.sv
`timescale 1ns / 1ps

module tb_polynomial_evaluator_top;

   localparam int MAX_DEGREE    = polyeval_pkg::DEFAULT_MAX_DEGREE;
   localparam int DEG_W         = polyeval_pkg::DEG_W;
   localparam int COEF_W        = polyeval_pkg::COEF_W;
   localparam int X_W           = polyeval_pkg::X_W;
   localparam int ACC_W         = polyeval_pkg::ACC_W;
   localparam int SETTLE_CYCLES = 2 * MAX_DEGREE + 4;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 130;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_type;
   logic [DEG_W-1:0]          req_coef_index;
   logic signed [COEF_W-1:0]  req_coef_value;
   logic signed [X_W-1:0]     req_x_value;
   logic                      rsp_strobe;
   logic signed [ACC_W-1:0]   rsp_poly_value;
   logic                      rsp_saturated;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [DEG_W-1:0]          csr_degree;
   int                        error_total;
   int                        pending_results;
   int                        idle_cycles = 0;

   polynomial_evaluator_top #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_x_value    (req_x_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_poly_value (rsp_poly_value),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_degree     (csr_degree)
   );

   polynomial_evaluator_checker #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_x_value    (req_x_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_poly_value (rsp_poly_value),
      .rsp_saturated  (rsp_saturated),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_degree     (csr_degree),
      .error_count    (error_total),
      .pending_count  (pending_results)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Q4.12 value biased towards the extremes and towards magnitudes of one or less
   function automatic logic [15:0] pick_q412();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 8191)) - 16'd4096;
         3: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic issue(input logic kind, input logic [DEG_W-1:0] idx,
                        input logic [COEF_W-1:0] coef, input logic [X_W-1:0] x);
      start          = 1'b1;
      req_type       = kind;
      req_coef_index = idx;
      req_coef_value = coef;
      req_x_value    = x;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      start = 1'b0;
      repeat (cycles) begin
         req_type       = 1'($urandom_range(0, 1));
         req_coef_index = DEG_W'($urandom);
         req_coef_value = pick_q412();
         req_x_value    = pick_q412();
         @(negedge clock);
      end
   endtask

   task automatic set_degree(input logic [DEG_W-1:0] d);
      start = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid  = 1'b1;
      csr_degree = d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic             kind;
      logic [DEG_W-1:0] next_degree;
      start          = 1'b0;
      req_type       = polyeval_pkg::REQ_WRITE;
      req_coef_index = '0;
      req_coef_value = '0;
      req_x_value    = '0;
      csr_valid      = 1'b0;
      csr_degree     = '0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // constant term only, empty table then extremes
      set_degree('0);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h1234, 16'h0000);
      issue(polyeval_pkg::REQ_WRITE, 4'd0, 16'h8000, 16'h7fff);
      issue(polyeval_pkg::REQ_EVAL,  4'd5, 16'h7fff, 16'h7fff);
      issue(polyeval_pkg::REQ_WRITE, 4'd0, 16'h7fff, 16'h8000);
      issue(polyeval_pkg::REQ_EVAL,  4'd9, 16'h8000, 16'h8000);

      // full degree, saturation both ways
      set_degree(DEG_W'(MAX_DEGREE));
      issue(polyeval_pkg::REQ_WRITE, DEG_W'(MAX_DEGREE), 16'h7fff, 16'h0000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h8000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h7fff);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h0000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h0001);

      // linear, rounding on the half and large products
      set_degree(4'd1);
      issue(polyeval_pkg::REQ_WRITE, 4'd1, 16'hffff, 16'h0000);
      issue(polyeval_pkg::REQ_WRITE, 4'd0, 16'h0000, 16'h0000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h0080);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'hff80);
      issue(polyeval_pkg::REQ_WRITE, 4'd1, 16'h8000, 16'h0000);
      issue(polyeval_pkg::REQ_WRITE, 4'd0, 16'h8000, 16'h0000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h8000);
      issue(polyeval_pkg::REQ_EVAL,  4'd0, 16'h0000, 16'h7fff);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         next_degree = (ph == 0) ? DEG_W'(MAX_DEGREE) :
                       (ph == 1) ? '0 : DEG_W'($urandom_range(0, MAX_DEGREE));
         set_degree(next_degree);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph != RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
               idle_gap($urandom_range(1, 10));
            kind = ($urandom_range(0, 99) < 45) ? polyeval_pkg::REQ_WRITE
                                                 : polyeval_pkg::REQ_EVAL;
            issue(kind, DEG_W'($urandom), pick_q412(), pick_q412());
         end
      end

      start = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_total == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
